>>> rtl/ket_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the keyed entry table.
// No dependencies; used by every module of the block.
package ket_pkg;

   localparam int ENTRIES     = 16;
   localparam int HANDLE_BITS = 16;

   localparam int KEY_W    = 64;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int FOUND_W  = 16;
   localparam int USED_W   = 5;
   localparam int HSW      = (HANDLE_BITS < FOUND_W) ? HANDLE_BITS : FOUND_W;
   localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W    = $clog2(ENTRIES + 1);

   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DUP  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_INSERT,
      OP_REMOVE
   } op_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [HSW-1:0]   handle;
      op_type           op;
   } cell_ctl_type;

   typedef struct packed {
      logic           valid;
      logic           hit;
      logic [HSW-1:0] handle;
   } probe_type;

endpackage

>>> rtl/ket_cell.sv
`timescale 1ns / 1ps
// One table cell: holds one key and handle, compares a passing probe and
// shifts its entry to a neighbor on insert or remove. Depends on ket_pkg.
module ket_cell import ket_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [IDX_W-1:0]   idx,
   input  logic [CNT_W-1:0]   cnt,
   input  cell_ctl_type       ctl,
   input  logic [KEY_W-1:0]   prev_key,
   input  logic [HSW-1:0]     prev_handle,
   input  logic [KEY_W-1:0]   next_key,
   input  logic [HSW-1:0]     next_handle,
   input  probe_type          probe_in,
   output probe_type          probe_out,
   output logic [KEY_W-1:0]   key_out,
   output logic [HSW-1:0]     handle_out
);

   logic [KEY_W-1:0] key_ff;
   logic [HSW-1:0]   handle_ff;
   logic             shift_ff;
   probe_type        probe_ff;
   probe_type        probe_in_w;
   logic             here;

   assign here = probe_in.valid && (CNT_W'(idx) < cnt) && (key_ff == ctl.key);

   always_comb begin
      probe_in_w.valid  = probe_in.valid;
      probe_in_w.hit    = probe_in.hit | here;
      probe_in_w.handle = here ? handle_ff : probe_in.handle;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
         shift_ff <= 1'b0;
      end else begin
         probe_ff <= probe_in_w;
         if (probe_in.valid) begin
            shift_ff <= probe_in.hit | here;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.op == OP_INSERT) begin
         key_ff    <= prev_key;
         handle_ff <= prev_handle;
      end else if (ctl.op == OP_REMOVE && shift_ff) begin
         key_ff    <= next_key;
         handle_ff <= next_handle;
      end
   end

   assign probe_out  = probe_ff;
   assign key_out    = key_ff;
   assign handle_out = handle_ff;

endmodule

>>> rtl/ket_ctrl.sv
`timescale 1ns / 1ps
// Command sequencer: takes an item, launches a probe down the cell chain,
// decides the outcome, drives the cell update and the result register.
// Depends on ket_pkg.
module ket_ctrl import ket_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [79:0]         req_tdata,   // client_key[63:0], entry_handle[79:64]
   input  logic [CMD_W-1:0]    req_tuser,   // cmd[1:0]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,   // found_handle[15:0], entries_used[20:16]
   output logic [STATUS_W-1:0] rsp_tuser,   // status[1:0]
   output cell_ctl_type        cell_ctl,
   output probe_type           probe_start,
   input  probe_type           probe_done,
   output logic [CNT_W-1:0]    cnt
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_OUT
   } state_type;

   state_type           state_ff;
   logic [CMD_W-1:0]    cmd_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [HSW-1:0]      hnd_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                start_ff;
   op_type              op_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [HSW-1:0]      found_ff;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [FOUND_W-1:0]  rsp_found_ff;
   logic [USED_W-1:0]   rsp_used_ff;

   logic [STATUS_W-1:0] dec_status;
   logic [HSW-1:0]      dec_found;
   op_type              dec_op;
   logic [CNT_W-1:0]    dec_cnt;
   logic                out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      dec_status = ST_OK;
      dec_found  = '0;
      dec_op     = OP_NONE;
      dec_cnt    = cnt_ff;
      case (cmd_ff)
         CMD_LOOKUP: begin
            if (probe_done.hit) begin
               dec_found = probe_done.handle;
            end else begin
               dec_status = ST_MISS;
            end
         end
         CMD_INSERT: begin
            if (cnt_ff == CNT_W'(ENTRIES)) begin
               dec_status = ST_FULL;
            end else if (probe_done.hit) begin
               dec_status = ST_DUP;
            end else begin
               dec_op  = OP_INSERT;
               dec_cnt = CNT_W'(cnt_ff + 1'b1);
            end
         end
         CMD_REMOVE: begin
            if (probe_done.hit) begin
               dec_found = probe_done.handle;
               dec_op    = OP_REMOVE;
               dec_cnt   = CNT_W'(cnt_ff - 1'b1);
            end else begin
               dec_status = ST_MISS;
            end
         end
         default: begin
            dec_status = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         start_ff     <= 1'b0;
         op_ff        <= OP_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= (state_ff == ST_IDLE) && req_tvalid;
         op_ff    <= (state_ff == ST_SCAN && probe_done.valid) ? dec_op : OP_NONE;
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  cmd_ff   <= req_tuser;
                  key_ff   <= req_tdata[63:0];
                  hnd_ff   <= HSW'(req_tdata[79:64]);
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (probe_done.valid) begin
                  status_ff <= dec_status;
                  found_ff  <= dec_found;
                  cnt_ff    <= dec_cnt;
                  state_ff  <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_status_ff <= status_ff;
                  rsp_found_ff  <= FOUND_W'(found_ff);
                  rsp_used_ff   <= USED_W'(cnt_ff);
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_used_ff, rsp_found_ff};

   assign cell_ctl.key    = key_ff;
   assign cell_ctl.handle = hnd_ff;
   assign cell_ctl.op     = op_ff;

   assign probe_start.valid  = start_ff;
   assign probe_start.hit    = 1'b0;
   assign probe_start.handle = '0;

   assign cnt = cnt_ff;

   a_accept_starts_probe: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_SCAN && start_ff)
      else $error("accepted item did not launch a probe");

   a_probe_done_in_scan: assert property (@(posedge clock) disable iff (reset)
      probe_done.valid |-> state_ff == ST_SCAN)
      else $error("probe finished outside of a scan");

   a_update_after_scan: assert property (@(posedge clock) disable iff (reset)
      op_ff != OP_NONE |-> state_ff == ST_OUT && $past(probe_done.valid))
      else $error("cell update not tied to a finished scan");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result raised outside of output state");

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      op_ff == OP_INSERT |-> cnt_ff != '0)
      else $error("insert left the table empty");

endmodule

>>> rtl/keyed_entry_table_unit.sv
`timescale 1ns / 1ps
// Top level of the keyed entry table: sequencer plus a chain of table cells.
// Depends on ket_pkg, ket_cell and ket_ctrl.
//
// Usage:
//   req channel: req_tuser carries cmd (lookup, insert, remove); req_tdata
//   carries the 64-bit key and the handle stored on insert.
//   rsp channel: one item per request; rsp_tuser carries the status
//   (ok, full, duplicate, not found), rsp_tdata the found handle and the
//   number of entries in use after the command.
//   Each command sends a probe through the cell chain, one cell per cycle,
//   then updates all cells together: insert shifts every entry up and
//   puts the new one in cell 0, remove shifts the entries above the match
//   down by one.
//   From accept, the probe walks the chain, a decide step registers the
//   outcome and the output register offers the result. One command is in
//   flight at a time; the next can be taken from the cycle after its result
//   is loaded into the output register, so no new request is taken until
//   the last result is loaded, which waits while the receiver holds off.
//   Reset empties the table and drops any result not yet taken. While
//   rsp_tready is low a result holds and no further command completes.
module keyed_entry_table_unit import ket_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [79:0]         req_tdata,   // client_key[63:0], entry_handle[79:64]
   input  logic [CMD_W-1:0]    req_tuser,   // cmd[1:0]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,   // found_handle[15:0], entries_used[20:16]
   output logic [STATUS_W-1:0] rsp_tuser    // status[1:0]
);

   cell_ctl_type     cell_ctl;
   logic [CNT_W-1:0] cnt;
   probe_type        probes [0:ENTRIES];
   logic [KEY_W-1:0] keys [0:ENTRIES-1];
   logic [HSW-1:0]   handles [0:ENTRIES-1];

   ket_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .cell_ctl    (cell_ctl),
      .probe_start (probes[0]),
      .probe_done  (probes[ENTRIES]),
      .cnt         (cnt)
   );

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic [KEY_W-1:0] prev_key;
      logic [HSW-1:0]   prev_handle;
      logic [KEY_W-1:0] next_key;
      logic [HSW-1:0]   next_handle;

      if (i == 0) begin : g_first
         assign prev_key    = cell_ctl.key;
         assign prev_handle = cell_ctl.handle;
      end else begin : g_mid
         assign prev_key    = keys[i-1];
         assign prev_handle = handles[i-1];
      end

      if (i == ENTRIES - 1) begin : g_last
         assign next_key    = keys[i];
         assign next_handle = handles[i];
      end else begin : g_inner
         assign next_key    = keys[i+1];
         assign next_handle = handles[i+1];
      end

      ket_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .idx         (IDX_W'(i)),
         .cnt         (cnt),
         .ctl         (cell_ctl),
         .prev_key    (prev_key),
         .prev_handle (prev_handle),
         .next_key    (next_key),
         .next_handle (next_handle),
         .probe_in    (probes[i]),
         .probe_out   (probes[i+1]),
         .key_out     (keys[i]),
         .handle_out  (handles[i])
      );
   end

endmodule

>>> bench/keyed_entry_table_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for keyed_entry_table_unit: directed table with expected results,
// then random commands over a key pool checked against a shadow copy of the key table.
// Depends on ket_pkg and the keyed_entry_table_unit RTL.
module keyed_entry_table_unit_tb import ket_pkg::*; ();

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 424;
   localparam int CALM_ITEMS   = 60;
   localparam int LONG_HOLD    = 250;
   localparam int POOL_SIZE    = 32;
   localparam int DRAIN_CYCLES = 30;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FOUND_W-1:0]  handle;
      logic [USED_W-1:0]   used;
   } table_reply_type;

   typedef struct {
      logic [CMD_W-1:0]   cmd;
      logic [KEY_W-1:0]   key;
      logic [FOUND_W-1:0] handle;
      bit                 typed;
      table_reply_type    reply;
   } dir_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [79:0]         req_tdata = '0;    // client_key[63:0], entry_handle[79:64]
   logic [CMD_W-1:0]    req_tuser = '0;    // cmd[1:0]
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [23:0]         rsp_tdata;         // found_handle[15:0], entries_used[20:16]
   logic [STATUS_W-1:0] rsp_tuser;         // status[1:0]

   logic [KEY_W-1:0]   shadow_key [ENTRIES];
   logic [FOUND_W-1:0] shadow_handle [ENTRIES];
   int                 shadow_count = 0;
   logic [KEY_W-1:0]   key_pool [POOL_SIZE];

   table_reply_type replies_due [$];
   dir_row_type     directed_rows [$];
   int              mismatch_count = 0;
   int              results_seen = 0;
   int              cmd_seen [4] = '{0, 0, 0, 0};
   int              status_seen [4] = '{0, 0, 0, 0};
   int              peak_fill = 0;
   bit              calm = 1'b0;

   keyed_entry_table_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic table_reply_type table_apply(input logic [CMD_W-1:0] cmd,
                                                   input logic [KEY_W-1:0] key,
                                                   input logic [FOUND_W-1:0] handle);
      table_reply_type r;
      int slot;
      r.status = ST_OK;
      r.handle = '0;
      slot = -1;
      for (int i = 0; i < shadow_count; i++) begin
         if (slot < 0 && shadow_key[i] == key) slot = i;
      end
      case (cmd)
         CMD_LOOKUP: begin
            if (slot >= 0) r.handle = shadow_handle[slot];
            else r.status = ST_MISS;
         end
         CMD_INSERT: begin
            if (shadow_count >= ENTRIES) begin
               r.status = ST_FULL;
            end else if (slot >= 0) begin
               r.status = ST_DUP;
            end else begin
               shadow_key[shadow_count]    = key;
               shadow_handle[shadow_count] = handle & FOUND_W'((65'd1 << HANDLE_BITS) - 1);
               shadow_count++;
            end
         end
         CMD_REMOVE: begin
            if (slot >= 0) begin
               r.handle = shadow_handle[slot];
               shadow_count--;
               shadow_key[slot]    = shadow_key[shadow_count];
               shadow_handle[slot] = shadow_handle[shadow_count];
            end else begin
               r.status = ST_MISS;
            end
         end
         default: ;
      endcase
      r.used = USED_W'(shadow_count);
      return r;
   endfunction

   task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                          input logic [FOUND_W-1:0] handle, input bit typed,
                          input logic [STATUS_W-1:0] status, input logic [FOUND_W-1:0] found,
                          input logic [USED_W-1:0] used);
      dir_row_type row;
      row.cmd = cmd;
      row.key = key;
      row.handle = handle;
      row.typed = typed;
      row.reply = '{status: status, handle: found, used: used};
      directed_rows.push_back(row);
   endtask

   task automatic offer_item(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                             input logic [FOUND_W-1:0] handle, input bit typed,
                             input table_reply_type typed_reply);
      table_reply_type pred;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {handle, key};
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      pred = table_apply(cmd, key, handle);
      replies_due.push_back(typed ? typed_reply : pred);
      cmd_seen[cmd]++;
      status_seen[pred.status]++;
      if (shadow_count > peak_fill) peak_fill = shadow_count;
   endtask

   task automatic idle_gap(input int pct);
      if ($urandom_range(0, 99) < pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   initial begin : stimulus
      logic [CMD_W-1:0]   cmd;
      logic [KEY_W-1:0]   key;
      logic [FOUND_W-1:0] handle;
      int                 gap_pct;
      int                 roll;
      bit                 filling;

      add_row(CMD_LOOKUP, '0, '0, 1, ST_MISS, '0, 5'd0);
      add_row(CMD_REMOVE, '1, '0, 1, ST_MISS, '0, 5'd0);
      add_row(CMD_UNUSED, 64'h5555_5555_5555_5555, 16'hAAAA, 1, ST_OK, '0, 5'd0);
      add_row(CMD_INSERT, '0, '0, 1, ST_OK, '0, 5'd1);
      add_row(CMD_INSERT, '1, '1, 1, ST_OK, '0, 5'd2);
      add_row(CMD_INSERT, '0, 16'h1234, 1, ST_DUP, '0, 5'd2);
      add_row(CMD_LOOKUP, '1, '0, 1, ST_OK, 16'hFFFF, 5'd2);
      for (int i = 0; i < ENTRIES - 2; i++) begin
         add_row(CMD_INSERT, 64'hA5A5_5A5A_0000_0000 + 64'(i) * 64'h0001_0001_0001,
                 FOUND_W'(16'h0101 * (i + 1)), 0, ST_OK, '0, '0);
      end
      add_row(CMD_INSERT, '1, 16'h4321, 1, ST_FULL, '0, 5'd16);
      add_row(CMD_INSERT, 64'h0F0F_0F0F_0F0F_0F0F, 16'h7777, 1, ST_FULL, '0, 5'd16);
      add_row(CMD_REMOVE, '0, '0, 1, ST_OK, '0, 5'd15);
      add_row(CMD_LOOKUP, '0, '0, 1, ST_MISS, '0, 5'd15);
      add_row(CMD_UNUSED, '1, '1, 1, ST_OK, '0, 5'd15);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         offer_item(directed_rows[i].cmd, directed_rows[i].key, directed_rows[i].handle,
                    directed_rows[i].typed, directed_rows[i].reply);
         idle_gap(20);
      end

      gap_pct = 0;
      filling = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) begin
            filling = ~filling;
            roll = $urandom_range(0, 2);
            gap_pct = (roll == 0) ? 0 : (roll == 1) ? 15 : 40;
            foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
         end
         if (n >= RANDOM_ITEMS - CALM_ITEMS) begin
            calm = 1'b1;
            gap_pct = 0;
         end
         roll = $urandom_range(0, 99);
         if (roll < 5) cmd = CMD_UNUSED;
         else if (roll < 25) cmd = CMD_LOOKUP;
         else if (roll < (filling ? 80 : 50)) cmd = CMD_INSERT;
         else cmd = CMD_REMOVE;
         roll = $urandom_range(0, 99);
         if (shadow_count > 0 && roll < (cmd == CMD_INSERT ? 25 : 60))
            key = shadow_key[$urandom_range(0, shadow_count - 1)];
         else if (roll < 85)
            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         else
            key = {$urandom, $urandom};
         handle = FOUND_W'($urandom);
         offer_item(cmd, key, handle, 0, '0);
         idle_gap(gap_pct);
      end
      req_tvalid <= 1'b0;

      while (replies_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d lookups, %0d inserts, %0d removes, %0d unused commands;",
               cmd_seen[CMD_LOOKUP], cmd_seen[CMD_INSERT], cmd_seen[CMD_REMOVE],
               cmd_seen[CMD_UNUSED]);
      $display("peak fill %0d; outcomes: %0d ok, %0d full, %0d duplicate, %0d not found; %0d results checked.",
               peak_fill, status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_DUP],
               status_seen[ST_MISS], results_seen);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin : receiver
      table_reply_type want;
      int stall_left;
      int stall_pct;
      int cycle;
      bit long_hold_done;
      stall_left = 0;
      stall_pct = 0;
      cycle = 0;
      long_hold_done = 1'b0;
      forever begin
         @(posedge clock);
         cycle++;
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
            results_seen++;
            if (replies_due.size() == 0) begin
               $error("result item with no command pending");
               mismatch_count++;
            end else begin
               want = replies_due.pop_front();
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  mismatch_count++;
               end
               if (rsp_tdata[15:0] !== want.handle) begin
                  $error("found_handle: expected %h, got %h", want.handle, rsp_tdata[15:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[20:16] !== want.used) begin
                  $error("entries_used: expected %0d, got %0d", want.used, rsp_tdata[20:16]);
                  mismatch_count++;
               end
            end
         end
         if (cycle % 64 == 0) stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
         if (stall_left > 0) begin
            stall_left--;
         end else if (!calm && !long_hold_done && results_seen >= 120) begin
            // hold off long enough for the input side to back up
            stall_left = LONG_HOLD;
            long_hold_done = 1'b1;
         end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(1, 18);
         end
         rsp_tready <= (stall_left == 0);
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
